// ----- sv/dcu_pkg.sv -----
// Shared types and character constants for the DNS character-string unescaper.
package dcu_pkg;

  typedef enum logic [2:0] {
    PH_SKIP = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_DIG1 = 3'd3,
    PH_DIG2 = 3'd4
  } phase_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [9:0] ESC_MAX = 10'd255;

  typedef struct packed {
    logic       kind;
    logic [7:0] value_byte;
    logic       failed;
    logic       consumed;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

endpackage

// ----- sv/dcu_front.sv -----
// Front end: parses each character and produces the results it causes as one queue entry.
module dcu_front import dcu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       end_of_text,
  output logic       push,
  output entry_t     entry
);

  phase_t     ph_r, ph_nxt;
  logic       quotes_r, quotes_nxt;
  logic       err_r, err_nxt;
  logic [6:0] esc_r, esc_nxt;
  logic [7:0] held_r, held_nxt;

  logic       do_body;
  logic       fin;
  logic       fin_used;
  logic       dig_ok;
  logic [3:0] dig;
  logic [9:0] full_val;
  logic [1:0] cnt;
  result_t    res [2];

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
           (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic result_t mk(input logic k, input logic [7:0] b, input logic f,
                                 input logic u);
    result_t r;
    r.kind       = k;
    r.value_byte = b;
    r.failed     = f;
    r.consumed   = u;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_SKIP;
      quotes_r <= 1'b0;
      err_r    <= 1'b0;
      esc_r    <= 7'd0;
      held_r   <= 8'd0;
    end else if (accept) begin
      ph_r     <= ph_nxt;
      quotes_r <= quotes_nxt;
      err_r    <= err_nxt;
      esc_r    <= esc_nxt;
      held_r   <= held_nxt;
    end
  end

  always_comb begin
    ph_nxt     = ph_r;
    quotes_nxt = quotes_r;
    err_nxt    = err_r;
    esc_nxt    = esc_r;
    held_nxt   = held_r;
    do_body    = 1'b0;
    fin        = 1'b0;
    fin_used   = 1'b0;
    cnt        = 2'd0;
    res[0]     = '0;
    res[1]     = '0;
    dig_ok     = !end_of_text && (ch >= CH_ZERO) && (ch <= CH_NINE);
    dig        = ch[3:0];
    full_val   = 10'(({3'b000, esc_r} * 10'd10) + {6'd0, dig});

    unique case (ph_r)
      PH_BODY: begin
        do_body = 1'b1;
      end
      PH_ESC: begin
        if (end_of_text) begin
          err_nxt = 1'b1;
          fin     = 1'b1;
        end else if (dig_ok) begin
          esc_nxt = {3'b000, dig};
          ph_nxt  = PH_DIG1;
        end else begin
          res[cnt[0]] = mk(KIND_DATA, ch, 1'b0, 1'b0);
          cnt         = cnt + 2'd1;
          ph_nxt      = PH_BODY;
        end
      end
      PH_DIG1: begin
        if (dig_ok) begin
          held_nxt = ch;
          esc_nxt  = 7'(full_val);
          ph_nxt   = PH_DIG2;
        end else begin
          err_nxt = 1'b1;
          esc_nxt = 7'd0;
          do_body = 1'b1;
        end
      end
      PH_DIG2: begin
        esc_nxt = 7'd0;
        if (dig_ok) begin
          ph_nxt = PH_BODY;
          if (full_val <= ESC_MAX) begin
            res[cnt[0]] = mk(KIND_DATA, full_val[7:0], 1'b0, 1'b0);
            cnt         = cnt + 2'd1;
          end else begin
            err_nxt     = 1'b1;
            res[cnt[0]] = mk(KIND_DATA, held_r, 1'b0, 1'b0);
            cnt         = cnt + 2'd1;
            res[cnt[0]] = mk(KIND_DATA, ch, 1'b0, 1'b0);
            cnt         = cnt + 2'd1;
          end
        end else begin
          err_nxt     = 1'b1;
          res[cnt[0]] = mk(KIND_DATA, held_r, 1'b0, 1'b0);
          cnt         = cnt + 2'd1;
          do_body     = 1'b1;
        end
      end
      default: begin
        ph_nxt = PH_SKIP;
        if (end_of_text) begin
          err_nxt = 1'b1;
          fin     = 1'b1;
        end else if ((ch == CH_SPACE) || (ch == CH_TAB)) begin
          ph_nxt = PH_SKIP;
        end else if (ch == CH_DASH) begin
          fin      = 1'b1;
          fin_used = 1'b1;
        end else if (ch == CH_QUOTE) begin
          quotes_nxt = 1'b1;
          ph_nxt     = PH_BODY;
        end else if (is_delim(ch)) begin
          err_nxt = 1'b1;
          fin     = 1'b1;
        end else begin
          quotes_nxt = 1'b0;
          do_body    = 1'b1;
        end
      end
    endcase

    if (do_body) begin
      ph_nxt = PH_BODY;
      if (end_of_text) begin
        if (quotes_nxt) begin
          err_nxt = 1'b1;
        end
        fin = 1'b1;
      end else if (quotes_nxt && (ch == CH_QUOTE)) begin
        fin      = 1'b1;
        fin_used = 1'b1;
      end else if (!quotes_nxt && is_delim(ch)) begin
        fin = 1'b1;
      end else if (ch == CH_BSLASH) begin
        ph_nxt = PH_ESC;
      end else begin
        res[cnt[0]] = mk(KIND_DATA, ch, 1'b0, 1'b0);
        cnt         = cnt + 2'd1;
      end
    end

    if (fin) begin
      res[cnt[0]] = mk(KIND_FINISH, 8'd0, err_nxt, fin_used);
      cnt         = cnt + 2'd1;
      ph_nxt      = PH_SKIP;
      quotes_nxt  = 1'b0;
      err_nxt     = 1'b0;
      esc_nxt     = 7'd0;
      held_nxt    = 8'd0;
    end

    push      = accept && (cnt != 2'd0);
    entry.two = cnt[1];
    entry.r0  = res[0];
    entry.r1  = res[1];
  end

endmodule

// ----- sv/dcu_queue.sv -----
// Small FIFO of result entries between the parser and the output stage.
module dcu_queue import dcu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  entry_t        mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr;
  logic          do_rd;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ----- sv/dcu_back.sv -----
// Back end: expands each queue entry into one or two output transactions.
module dcu_back import dcu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic    valid_r, valid_nxt;
  logic    sel_r, sel_nxt;
  result_t res_r;
  logic    last_r;
  logic    load;
  logic    is_last;
  result_t cur;

  always_comb begin
    load      = !empty && (!valid_r || out_tready);
    cur       = sel_r ? head.r1 : head.r0;
    is_last   = !head.two || sel_r;
    pop       = load && is_last;
    sel_nxt   = load ? !is_last : sel_r;
    valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= cur;
      last_r <= is_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, res_r.consumed, res_r.failed, res_r.value_byte};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = last_r;

endmodule

// ----- sv/dns_charstring_unescape.sv -----
// Top level of the DNS character-string unescaper.
// Zone-file text enters one character per transaction on the in_ channel:
// in_tdata carries the character and in_tuser flags the end of the text.
// Each value yields zero or more data bytes on the out_ channel
// (out_tuser low) and then one finish transaction (out_tuser high) that
// carries the sticky error and whether the final character was consumed.
// out_tlast marks the last output transaction caused by one input character.
// A character is accepted every cycle while the result queue has room.
// Its results pass through the result queue and then the output register.
// The output stage sends one result per cycle while out_tready is high, so
// a character with two results occupies it for both; the queue of
// QUEUE_DEPTH entries absorbs that and lets input continue meanwhile.
// When the receiver stalls, the queue fills and in_tready drops.
// Reset clears the parser to the leading-whitespace state and empties the
// queue and the output register.
module dns_charstring_unescape import dcu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch
  input  logic        in_tuser,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // value_byte, failed, consumed, zero fill
  output logic        out_tuser,  // kind
  output logic        out_tlast
);

  logic   accept;
  logic   push;
  entry_t entry;
  logic   full;
  logic   empty;
  logic   pop;
  entry_t head;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  dcu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .ch          (in_tdata),
    .end_of_text (in_tuser),
    .push        (push),
    .entry       (entry)
  );

  dcu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (entry),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  dcu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the DNS character-string unescaper: directed table, then random zone-file values.
`timescale 1ns / 1ps

module tb_top import dcu_pkg::*; ();

  typedef struct packed {
    result_t r;
    logic    last;
  } expected_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    bit         typed;
    int         n;
    result_t    r;
  } row_t;

  localparam int DIR_ROWS     = 26;
  localparam int RANDOM_CHARS = 1000;
  localparam int TAIL_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  dns_charstring_unescape u_top (.*);

  always #1 clk = ~clk;

  initial begin
    #500000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Parser state mirrored from the block.
  phase_t     ph;
  logic       quoted;
  logic [7:0] held;
  logic [9:0] esc_val;
  logic       err;

  result_t   step_out[$];
  expected_t due_results[$];

  int  errors;
  int  n_sent;
  int  n_results;
  int  n_finishes;
  bit  burst_in;
  bit  burst_out;

  logic [7:0] delims [7] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_SEMI, CH_LPAREN, CH_RPAREN};

  row_t dir_rows [DIR_ROWS] = '{
    '{8'h00,     1'b1, 1'b1, 1, '{KIND_FINISH, 8'h00, 1'b1, 1'b0}},
    '{CH_SPACE,  1'b0, 1'b1, 0, '0},
    '{CH_TAB,    1'b0, 1'b1, 0, '0},
    '{CH_DASH,   1'b0, 1'b1, 1, '{KIND_FINISH, 8'h00, 1'b0, 1'b1}},
    '{CH_SEMI,   1'b0, 1'b1, 1, '{KIND_FINISH, 8'h00, 1'b1, 1'b0}},
    '{CH_QUOTE,  1'b0, 1'b1, 0, '0},
    '{8'hFF,     1'b0, 1'b1, 1, '{KIND_DATA, 8'hFF, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b0, 0, '0},
    '{"2",       1'b0, 1'b0, 0, '0},
    '{"5",       1'b0, 1'b0, 0, '0},
    '{"5",       1'b0, 1'b0, 0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 0, '0},
    '{"9",       1'b0, 1'b0, 0, '0},
    '{"9",       1'b0, 1'b0, 0, '0},
    '{"9",       1'b0, 1'b0, 0, '0},
    '{CH_QUOTE,  1'b0, 1'b0, 0, '0},
    '{8'h00,     1'b0, 1'b1, 1, '{KIND_DATA, 8'h00, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b0, 0, '0},
    '{"1",       1'b0, 1'b0, 0, '0},
    '{"x",       1'b0, 1'b0, 0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, 0, '0},
    '{"1",       1'b0, 1'b0, 0, '0},
    '{"2",       1'b0, 1'b0, 0, '0},
    '{8'hA5,     1'b1, 1'b0, 0, '0},
    '{"a",       1'b0, 1'b0, 0, '0},
    '{8'h5A,     1'b1, 1'b1, 1, '{KIND_FINISH, 8'h00, 1'b0, 1'b0}}
  };

  function automatic bit is_dec_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_delim(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN;
  endfunction

  function automatic void clear_parse();
    ph      = PH_SKIP;
    quoted  = 1'b0;
    held    = 8'h00;
    esc_val = 10'd0;
    err     = 1'b0;
  endfunction

  function automatic void put_result(input logic kind, input logic [7:0] b,
                                     input logic f, input logic used);
    result_t r;
    r.kind       = kind;
    r.value_byte = b;
    r.failed     = f;
    r.consumed   = used;
    step_out.push_back(r);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    put_result(KIND_DATA, b, 1'b0, 1'b0);
  endfunction

  function automatic void close_value(input logic used);
    put_result(KIND_FINISH, 8'h00, err, used);
    clear_parse();
  endfunction

  function automatic void body_char(input logic [7:0] c, input logic eot);
    ph = PH_BODY;
    if (eot) begin
      if (quoted) err = 1'b1;
      close_value(1'b0);
    end else if (quoted && c == CH_QUOTE) begin
      close_value(1'b1);
    end else if (!quoted && is_delim(c)) begin
      close_value(1'b0);
    end else if (c == CH_BSLASH) begin
      ph = PH_ESC;
    end else begin
      put_byte(c);
    end
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic eot);
    int v;
    step_out.delete();
    case (ph)
      PH_BODY: body_char(c, eot);
      PH_ESC: begin
        if (eot) begin
          err = 1'b1;
          close_value(1'b0);
        end else if (is_dec_char(c)) begin
          esc_val = 10'(c - CH_ZERO);
          ph      = PH_DIG1;
        end else begin
          put_byte(c);
          ph = PH_BODY;
        end
      end
      PH_DIG1: begin
        if (!eot && is_dec_char(c)) begin
          held    = c;
          esc_val = 10'(esc_val * 10 + (c - CH_ZERO));
          ph      = PH_DIG2;
        end else begin
          err     = 1'b1;
          esc_val = 10'd0;
          body_char(c, eot);
        end
      end
      PH_DIG2: begin
        if (!eot && is_dec_char(c)) begin
          v       = int'(esc_val) * 10 + int'(c) - int'(CH_ZERO);
          esc_val = 10'd0;
          ph      = PH_BODY;
          if (v <= int'(ESC_MAX)) begin
            put_byte(8'(v));
          end else begin
            err = 1'b1;
            put_byte(held);
            put_byte(c);
          end
        end else begin
          err     = 1'b1;
          esc_val = 10'd0;
          put_byte(held);
          body_char(c, eot);
        end
      end
      default: begin
        ph = PH_SKIP;
        if (eot) begin
          err = 1'b1;
          close_value(1'b0);
        end else if (c == CH_SPACE || c == CH_TAB) begin
        end else if (c == CH_DASH) begin
          close_value(1'b1);
        end else if (c == CH_QUOTE) begin
          quoted = 1'b1;
          ph     = PH_BODY;
        end else if (is_delim(c)) begin
          err = 1'b1;
          close_value(1'b0);
        end else begin
          quoted = 1'b0;
          body_char(c, 1'b0);
        end
      end
    endcase
  endfunction

  function automatic void queue_step();
    expected_t e;
    foreach (step_out[i]) begin
      e.r    = step_out[i];
      e.last = (i == step_out.size() - 1);
      due_results.push_back(e);
    end
  endfunction

  // Enters and returns at a rising edge; returns at the edge of the transaction.
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    if ($urandom_range(0, 39) == 0) burst_in = !burst_in;
    gap = burst_in ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= eot;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic feed(input logic [7:0] c, input logic eot);
    send_char(c, eot);
    decode_char(c, eot);
    queue_step();
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte(input bit in_quotes);
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == CH_BSLASH || (in_quotes ? c == CH_QUOTE : is_delim(c)));
    return c;
  endfunction

  task automatic send_piece(input bit in_quotes);
    int sel;
    int v;
    int nd;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      feed(plain_byte(in_quotes), 1'b0);
    end else if (sel == 6) begin
      feed(CH_BSLASH, 1'b0);
      feed(8'($urandom), 1'b0);
    end else if (sel <= 8) begin
      v = $urandom_range(0, 255);
      feed(CH_BSLASH, 1'b0);
      feed(8'(CH_ZERO + v / 100), 1'b0);
      feed(8'(CH_ZERO + (v / 10) % 10), 1'b0);
      feed(8'(CH_ZERO + v % 10), 1'b0);
    end else begin
      // Over-range or truncated decimal escape.
      v  = $urandom_range(256, 999);
      nd = $urandom_range(1, 3);
      feed(CH_BSLASH, 1'b0);
      feed(8'(CH_ZERO + v / 100), 1'b0);
      if (nd >= 2) feed(8'(CH_ZERO + (v / 10) % 10), 1'b0);
      if (nd == 3) feed(8'(CH_ZERO + v % 10), 1'b0);
    end
  endtask

  task automatic send_value();
    int mode;
    int len;
    int sel;
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) feed($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    mode = $urandom_range(0, 99);
    len  = $urandom_range(0, 8);
    if (mode < 5) begin
      feed(CH_DASH, 1'b0);
    end else if (mode < 12) begin
      repeat ($urandom_range(1, 6)) feed(8'($urandom), $urandom_range(0, 7) == 0);
    end else if (mode < 55) begin
      feed(CH_QUOTE, 1'b0);
      repeat (len) send_piece(1'b1);
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        feed(CH_QUOTE, 1'b0);
      end else begin
        if (sel == 9) feed(CH_BSLASH, 1'b0);
        feed(8'($urandom), 1'b1);
      end
    end else begin
      do c = plain_byte(1'b0); while (c == CH_DASH || c == CH_QUOTE);
      feed(c, 1'b0);
      repeat (len) send_piece(1'b0);
      if ($urandom_range(0, 3) == 0) feed(8'($urandom), 1'b1);
      else feed(delims[$urandom_range(0, 6)], 1'b0);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    expected_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tuser) n_finishes++;
      if (due_results.size() == 0) begin
        $error("unexpected output transaction: tdata %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        e = due_results.pop_front();
        if (out_tuser !== e.r.kind) begin
          $error("kind: expected %0d, got %0d", e.r.kind, out_tuser);
          errors++;
        end
        if (out_tdata[7:0] !== e.r.value_byte) begin
          $error("value_byte: expected %h, got %h", e.r.value_byte, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[8] !== e.r.failed) begin
          $error("failed: expected %0d, got %0d", e.r.failed, out_tdata[8]);
          errors++;
        end
        if (out_tdata[9] !== e.r.consumed) begin
          $error("consumed: expected %0d, got %0d", e.r.consumed, out_tdata[9]);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_tlast);
          errors++;
        end
        if (out_tdata[15:10] !== 6'd0) begin
          $error("tdata fill: expected 0, got %h", out_tdata[15:10]);
          errors++;
        end
      end
    end
  end

  // Result receiver with random back-pressure.
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) burst_out = !burst_out;
      gap = burst_out ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    bit paused;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    errors    = 0;
    n_sent    = 0;
    paused    = 1'b0;
    clear_parse();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].ch, dir_rows[i].eot);
      decode_char(dir_rows[i].ch, dir_rows[i].eot);
      if (!dir_rows[i].typed) queue_step();
      else if (dir_rows[i].n == 1) due_results.push_back('{dir_rows[i].r, 1'b1});
    end
    drain();

    while (n_sent < DIR_ROWS + RANDOM_CHARS) begin
      send_value();
      if (!paused && n_sent > DIR_ROWS + RANDOM_CHARS / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Fed %0d text characters (directed and random values); checked %0d output",
             n_sent, n_results);
    $display("transactions, %0d of them value finishes, under random stalls on both sides.",
             n_finishes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- dns_charstring_unescape.f -----
sv/dcu_pkg.sv
sv/dcu_front.sv
sv/dcu_queue.sv
sv/dcu_back.sv
sv/dns_charstring_unescape.sv
tb/tb_top.sv
